/* rtl/time_weighted_speed_average_top_defines.svh */
// Assertion macros for the time weighted speed average block.
// Used by the port checker; no other dependencies.
`ifndef TIME_WEIGHTED_SPEED_AVERAGE_TOP_DEFINES_SVH
`define TIME_WEIGHTED_SPEED_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/twsa_pkg.sv */
// Shared types and constants for the time weighted speed average block.
// No dependencies.
package twsa_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int STAMP_W           = 32;
    localparam int SPEED_W           = 16;
    localparam int WINDOW_W          = 24;
    localparam int PROD_W            = WINDOW_W + SPEED_W;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd10000;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_QUERY = 1'b1
    } twsa_op_t;

    typedef struct packed {
        twsa_op_t             operation;
        logic [STAMP_W-1:0]   stamp_ms;
        logic [SPEED_W-1:0]   speed;
    } twsa_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0]   average_speed;
        logic                 valid_res;
    } twsa_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } twsa_div_stat_t;

endpackage

/* rtl/twsa_hist.sv */
// Sample history ring: timestamp and speed memory with write pointer and fill count.
// Depends on twsa_pkg.
module twsa_hist #(
    parameter int DEPTH = twsa_pkg::HISTORY_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [twsa_pkg::STAMP_W-1:0] wr_stamp,
    input  logic [twsa_pkg::SPEED_W-1:0] wr_speed,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [twsa_pkg::STAMP_W-1:0] rd_stamp,
    output logic [twsa_pkg::SPEED_W-1:0] rd_speed,
    output logic [ADDR_W-1:0]            write_slot,
    output logic [CNT_W-1:0]             fill_count
);
    import twsa_pkg::*;

    logic [STAMP_W-1:0] time_mem  [DEPTH];
    logic [SPEED_W-1:0] speed_mem [DEPTH];
    logic [ADDR_W-1:0]  write_slot_reg;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [SPEED_W-1:0] rd_speed_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[write_slot_reg]  <= wr_stamp;
            speed_mem[write_slot_reg] <= wr_speed;
        end
        if (rd_en) begin
            rd_stamp_reg <= time_mem[rd_addr];
            rd_speed_reg <= speed_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            fill_count_reg <= '0;
        end else if (wr_en) begin
            write_slot_reg <= (write_slot_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                   : write_slot_reg + 1'b1;
            if (fill_count_reg != CNT_W'(DEPTH)) begin
                fill_count_reg <= fill_count_reg + 1'b1;
            end
        end
    end

    assign rd_stamp   = rd_stamp_reg;
    assign rd_speed   = rd_speed_reg;
    assign write_slot = write_slot_reg;
    assign fill_count = fill_count_reg;

endmodule

/* rtl/twsa_div.sv */
// Serial restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on twsa_pkg; caller guarantees the quotient fits in SPEED_W bits.
module twsa_div #(
    parameter int WSUM_W = twsa_pkg::WINDOW_W + 7,
    localparam int DVD_W = WSUM_W + twsa_pkg::SPEED_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [DVD_W-1:0]               dividend,
    input  logic [WSUM_W-1:0]              divisor,
    output logic [twsa_pkg::SPEED_W-1:0]   quotient,
    output twsa_pkg::twsa_div_stat_t       stat
);
    import twsa_pkg::*;

    localparam int Q_W   = SPEED_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [WSUM_W-1:0] rem_reg;
    logic [Q_W-1:0]    bits_reg;
    logic [WSUM_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [WSUM_W:0]   trial;
    logic [WSUM_W:0]   diff;
    logic              ge;

    assign trial = {rem_reg, bits_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= dividend[DVD_W-1:Q_W];
                bits_reg <= dividend[Q_W-1:0];
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(Q_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
                bits_reg <= {bits_reg[Q_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = bits_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/time_weighted_speed_average_top.sv */
// Top level of the time weighted speed average block: sequencer, weight and
// multiply-accumulate datapath. Depends on twsa_pkg, twsa_hist and twsa_div.
//
//   channel   ports            carries
//   -------   --------------   ------------------------------------------
//   input     s_valid/s_ready  twsa_in_t: push a sample or query
//   result    m_valid/m_ready  twsa_out_t: one per query, none per push
//   config    cfg_wr_en        window_ms, 24 bits, written without wait
//
// A push is written to the history as it is accepted. A query is accepted, then walks
// the stored samples from the newest, each with a memory read, age check, multiply and
// accumulate through one multiplier, then the check, the 16-step serial divide with its
// done strobe and the output; a sample past the window ends the walk.
// Reset is synchronous, active low; the history starts empty.
// s_ready is low for the whole of a query; a finished result waits in the
// output register while pushes are still taken.
module time_weighted_speed_average_top #(
    parameter int HISTORY_DEPTH = twsa_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  twsa_pkg::twsa_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output twsa_pkg::twsa_out_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [twsa_pkg::WINDOW_W-1:0] cfg_wr_data
);
    import twsa_pkg::*;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int WSUM_W = WINDOW_W + CNT_W;
    localparam int ACC_W  = WSUM_W + SPEED_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_AGE,
        ST_MUL,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic [WINDOW_W-1:0] w_reg;
    logic [SPEED_W-1:0] spd_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    twsa_out_t          res_reg;
    twsa_out_t          m_data_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic [STAMP_W-1:0] rd_stamp;
    logic [SPEED_W-1:0] rd_speed;
    logic [ADDR_W-1:0]  write_slot;
    logic [CNT_W-1:0]   fill_count;
    logic [ADDR_W-1:0]  newest_addr;
    logic [STAMP_W-1:0] age;
    logic               too_old;
    logic [WINDOW_W-1:0] w_next;
    logic               div_start;
    logic [SPEED_W-1:0] quotient;
    twsa_div_stat_t     div_stat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign wr_en     = accept && (s_data.operation == OP_PUSH);
    assign rd_en     = (state_reg == ST_RD);
    assign div_start = (state_reg == ST_CHK) && (wsum_reg != '0);

    assign newest_addr = (write_slot == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                            : write_slot - 1'b1;
    assign age     = (now_reg >= rd_stamp) ? now_reg - rd_stamp : '0;
    assign too_old = age > {{(STAMP_W - WINDOW_W){1'b0}}, window_reg};
    assign w_next  = window_reg - age[WINDOW_W-1:0];

    twsa_hist #(
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_stamp  (s_data.stamp_ms),
        .wr_speed  (s_data.speed),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr_reg),
        .rd_stamp  (rd_stamp),
        .rd_speed  (rd_speed),
        .write_slot(write_slot),
        .fill_count(fill_count)
    );

    twsa_div #(
        .WSUM_W(WSUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(acc_reg),
        .divisor (wsum_reg),
        .quotient(quotient),
        .stat    (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_data.operation == OP_QUERY)) begin
                        now_reg     <= s_data.stamp_ms;
                        acc_reg     <= '0;
                        wsum_reg    <= '0;
                        remain_reg  <= fill_count;
                        rd_addr_reg <= newest_addr;
                        state_reg   <= (fill_count == '0) ? ST_CHK : ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_AGE;
                end
                ST_AGE: begin
                    w_reg     <= w_next;
                    spd_reg   <= rd_speed;
                    state_reg <= too_old ? ST_CHK : ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(w_reg) * PROD_W'(spd_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg     <= acc_reg + ACC_W'(prod_reg);
                    wsum_reg    <= wsum_reg + WSUM_W'(w_reg);
                    remain_reg  <= remain_reg - 1'b1;
                    rd_addr_reg <= (rd_addr_reg == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                                       : rd_addr_reg - 1'b1;
                    state_reg   <= (remain_reg == CNT_W'(1)) ? ST_CHK : ST_RD;
                end
                ST_CHK: begin
                    if (wsum_reg == '0) begin
                        res_reg.average_speed <= '0;
                        res_reg.valid_res     <= 1'b0;
                        state_reg             <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        res_reg.average_speed <= quotient;
                        res_reg.valid_res     <= 1'b1;
                        state_reg             <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/twsa_checker.sv */
// Port-level assertions for the time weighted speed average block, bound to the top.
// Depends on twsa_pkg and time_weighted_speed_average_top_defines.svh.
`include "time_weighted_speed_average_top_defines.svh"

module twsa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input twsa_pkg::twsa_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input twsa_pkg::twsa_out_t m_data
);
    import twsa_pkg::*;

    `TWSA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result request dropped or changed while stalled")

    `TWSA_ASSERT_NXT(a_query_busy, aclk, aresetn,
        s_valid && s_ready && (s_data.operation == OP_QUERY),
        !s_ready, "input ready right after a query request")

    `TWSA_ASSERT_NXT(a_push_silent, aclk, aresetn,
        s_valid && s_ready && (s_data.operation == OP_PUSH) && !m_valid,
        !m_valid, "result produced by a push request")

    `TWSA_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid && !m_data.valid_res,
        m_data.average_speed == '0, "invalid result with nonzero speed")

endmodule

bind time_weighted_speed_average_top twsa_checker u_twsa_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
